FILE: rtl/core/cetp_pkg.sv
// types, constants and helpers shared by the colour-escape text parser
// no dependencies; used by cetp_step and color_escape_text_parser
`default_nettype none

package cetp_pkg;

    localparam int TOKEN_DIGITS = 5;
    localparam int BUF_DEPTH    = TOKEN_DIGITS - 1;
    localparam int DIGIT_IDX_W  = $clog2(BUF_DEPTH);
    localparam int MAX_RESULTS  = TOKEN_DIGITS + 1;
    localparam int RUN_CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int DCOUNT_W     = 3;
    localparam int TVAL_W       = 17;

    localparam logic [7:0]  FORM_FEED  = 8'h0C;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [3:0]  DIGIT_HIGH = 4'h3;
    localparam logic [23:0] WHITE      = 24'hFFFFFF;

    typedef logic [BUF_DEPTH-1:0][3:0] cetp_digits_t;

    typedef struct packed {
        logic                token_active;
        logic [DCOUNT_W-1:0] digit_count;
        logic [TVAL_W-1:0]   token_value;
        logic [23:0]         color;
        logic                boundary_pending;
    } cetp_state_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [MAX_RESULTS-1:0]      seg;
        logic [RUN_CNT_W-1:0]        count;
        logic [23:0]                 color;
    } cetp_run_t;

    localparam cetp_state_t STATE_RESET = '{
        token_active:     1'b0,
        digit_count:      '0,
        token_value:      '0,
        color:            WHITE,
        boundary_pending: 1'b1
    };

    // rgb565 to rgb888 by bit replication, near-black forced to white
    function automatic logic [23:0] expand565(input logic [15:0] v);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r8 = {v[15:11], v[15:13]};
        g8 = {v[10:5], v[10:9]};
        b8 = {v[4:0], v[4:2]};
        if (r8[7:5] == 3'd0 && g8[7:5] == 3'd0 && b8[7:5] == 3'd0) begin
            return WHITE;
        end
        return {r8, g8, b8};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cetp_step.sv
// one-byte step of the parser: next state and the run of output words
// depends on cetp_pkg
`default_nettype none

module cetp_step (
    input  wire cetp_pkg::cetp_state_t  state_i,
    input  wire cetp_pkg::cetp_digits_t digits_i,
    input  wire logic [7:0]             text_byte_i,
    input  wire logic                   text_end_i,
    output cetp_pkg::cetp_state_t       state_o,
    output cetp_pkg::cetp_digits_t      digits_o,
    output cetp_pkg::cetp_run_t         run_o
);
    import cetp_pkg::*;

    always_comb begin
        cetp_state_t          st;
        cetp_digits_t         dg;
        cetp_run_t            run;
        logic [RUN_CNT_W-1:0] k;
        logic                 handled;
        logic                 is_digit;
        logic [3:0]           digit;

        st       = state_i;
        dg       = digits_i;
        run      = '0;
        run.color = state_i.color;
        k        = '0;
        handled  = 1'b0;
        is_digit = (text_byte_i >= CHAR_ZERO) && (text_byte_i <= CHAR_NINE);
        digit    = text_byte_i[3:0];

        if (st.token_active) begin
            if (is_digit) begin
                st.token_value = TVAL_W'((st.token_value << 3) + (st.token_value << 1)
                                         + TVAL_W'(digit));
                if (st.digit_count >= DCOUNT_W'(BUF_DEPTH)) begin
                    st.color            = expand565(st.token_value[15:0]);
                    st.boundary_pending = 1'b1;
                    st.token_active     = 1'b0;
                    st.digit_count      = '0;
                    st.token_value      = '0;
                end else begin
                    dg[st.digit_count[DIGIT_IDX_W-1:0]] = digit;
                    st.digit_count = st.digit_count + DCOUNT_W'(1);
                end
                handled = 1'b1;
            end else begin
                // failed token: form-feed alone, then the digits replayed
                run.chars[k] = FORM_FEED;
                run.seg[k]   = 1'b1;
                k = k + RUN_CNT_W'(1);
                for (int i = 0; i < BUF_DEPTH; i++) begin
                    if (DCOUNT_W'(i) < st.digit_count) begin
                        run.chars[k] = {DIGIT_HIGH, dg[i]};
                        run.seg[k]   = (i == 0);
                        k = k + RUN_CNT_W'(1);
                    end
                end
                st.boundary_pending = (st.digit_count == '0);
                st.token_active     = 1'b0;
                st.digit_count      = '0;
                st.token_value      = '0;
            end
        end

        if (!handled) begin
            if (text_byte_i == FORM_FEED) begin
                st.token_active     = 1'b1;
                st.digit_count      = '0;
                st.token_value      = '0;
                st.boundary_pending = 1'b1;
            end else begin
                run.chars[k] = text_byte_i;
                run.seg[k]   = st.boundary_pending;
                k = k + RUN_CNT_W'(1);
                st.boundary_pending = 1'b0;
            end
        end

        if (text_end_i) begin
            if (st.token_active) begin
                run.chars[k] = FORM_FEED;
                run.seg[k]   = 1'b1;
                k = k + RUN_CNT_W'(1);
                for (int i = 0; i < BUF_DEPTH; i++) begin
                    if (DCOUNT_W'(i) < st.digit_count) begin
                        run.chars[k] = {DIGIT_HIGH, dg[i]};
                        run.seg[k]   = (i == 0);
                        k = k + RUN_CNT_W'(1);
                    end
                end
                st.token_active = 1'b0;
                st.digit_count  = '0;
                st.token_value  = '0;
            end
            st.color            = WHITE;
            st.boundary_pending = 1'b1;
        end

        run.count = k;
        state_o   = st;
        digits_o  = dg;
        run_o     = run;
    end

endmodule

`default_nettype wire

FILE: rtl/core/color_escape_text_parser.sv
// top level of the colour-escape text parser: input register, step logic, run buffer
// depends on cetp_pkg and cetp_step
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_text_byte[7:0], s_text_end
//   m_       out  m_valid/m_ready    m_out_char[7:0], m_red, m_green, m_blue,
//                                    m_segment_start, m_run_last
//
// a byte is taken into the input register, stepped and its run of 0..6 output
// words loaded into the run buffer, which drives the m_ ports one word per cycle
// of m_ready; a byte yielding at most one word sustains one byte per cycle while
// m_ready stays high, a byte yielding more keeps the run buffer busy until its
// last word leaves, so a failed colour token (up to six words) holds the next
// byte in the input register meanwhile; a byte reaches the m_ ports through the
// input register and then the run buffer; aresetn (synchronous, active low)
// restores white, no token and a pending segment start; a stall on m_ready backs
// up through the run buffer into the input register and then s_ready
`default_nettype none

module color_escape_text_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       s_text_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue,
    output logic            m_segment_start,
    output logic            m_run_last
);
    import cetp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // parser state and digit buffer (buffer only read after being written)
    cetp_state_t  state_reg;
    cetp_state_t  state_next;
    cetp_digits_t digits_reg;
    cetp_digits_t digits_next;

    // run buffer holding the words of one byte
    cetp_run_t            run_reg;
    cetp_run_t            run_next;
    logic [RUN_CNT_W-1:0] run_idx_reg;

    logic run_done;
    logic run_free;
    logic proc_take;

    cetp_step u_step (
        .state_i     (state_reg),
        .digits_i    (digits_reg),
        .text_byte_i (in_byte_reg),
        .text_end_i  (in_end_reg),
        .state_o     (state_next),
        .digits_o    (digits_next),
        .run_o       (run_next)
    );

    // output side: current word of the run
    assign m_valid         = (run_reg.count != '0);
    assign m_out_char      = run_reg.chars[run_idx_reg];
    assign m_segment_start = run_reg.seg[run_idx_reg];
    assign m_red           = run_reg.color[23:16];
    assign m_green         = run_reg.color[15:8];
    assign m_blue          = run_reg.color[7:0];
    assign m_run_last      = (run_idx_reg == RUN_CNT_W'(run_reg.count - RUN_CNT_W'(1)));

    // buffer frees when empty or its last word leaves
    assign run_done  = m_valid && m_ready && m_run_last;
    assign run_free  = !m_valid || run_done;
    assign proc_take = in_valid_reg && run_free;
    assign s_ready   = !in_valid_reg || run_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_end_reg  <= s_text_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (proc_take) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_take) begin
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            run_idx_reg <= '0;
        end else if (proc_take) begin
            run_reg     <= run_next;
            run_idx_reg <= '0;
        end else if (run_done) begin
            run_reg.count <= '0;
            run_idx_reg   <= '0;
        end else if (m_valid && m_ready) begin
            run_idx_reg <= run_idx_reg + RUN_CNT_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    // word index never runs past the end of the run
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (run_idx_reg < run_reg.count))
        else $error("run index past run length");

    // a run never holds more words than one byte can cause
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg.count <= RUN_CNT_W'(MAX_RESULTS))
        else $error("run longer than maximum");

    // outside a token nothing is collected
    a_idle_token: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.token_active |->
            (state_reg.digit_count == '0) && (state_reg.token_value == '0))
        else $error("token residue while no token active");

    // a token never holds more digits than the buffer
    a_digit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.digit_count <= DCOUNT_W'(BUF_DEPTH))
        else $error("digit count beyond buffer");
`endif

endmodule

`default_nettype wire

FILE: tb/color_escape_text_parser_test.sv
// self-checking testbench for color_escape_text_parser: text bytes in, coloured glyph words out
// depends on cetp_pkg for the character codes, token length and white; no files are read
// a built-in parser model predicts every glyph word, the monitor checks them in order

module color_escape_text_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cetp_pkg::FORM_FEED;
    import cetp_pkg::CHAR_ZERO;
    import cetp_pkg::CHAR_NINE;
    import cetp_pkg::TOKEN_DIGITS;
    import cetp_pkg::WHITE;

    localparam int TEXT_ITEMS  = 360;
    localparam int STALL_LIMIT = 2000;   // cycles with no word moving on either channel
    localparam int DRAIN_WAIT  = 20;     // settle time after the last glyph word

    // one glyph word as seen on the m_ channel
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       seg;
        logic       last;
    } glyph_t;

    // one text word waiting to be sent; drain_first holds it back until all glyphs are in
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       drain_first;
    } text_item_t;

    // receiver stall behaviour, changed now and then
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKE
    } sink_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_text_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;
    logic       m_segment_start;
    logic       m_run_last;

    text_item_t text_queue[$];
    glyph_t     expected_glyphs[$];
    int         items_queued = 0;
    int         items_accepted = 0;
    int         error_count = 0;

    // parser model state, starting from the reset state
    logic        tok_open = 1'b0;
    logic [2:0]  tok_digits = 3'd0;
    logic [3:0]  tok_buf [0:TOKEN_DIGITS-2];
    logic [16:0] tok_value = 17'd0;
    logic [23:0] ink = WHITE;
    logic        new_segment = 1'b1;
    glyph_t      run_buf [0:TOKEN_DIGITS];
    int          run_len;

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall shaping
    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_phase = 0;
    int         choke_left = 0;

    int idle_cycles = 0;

    color_escape_text_parser i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_text_end      (s_text_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_segment_start (m_segment_start),
        .m_run_last      (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    // rgb565 widened by repeating the top bits; anything near black reads as white
    function automatic logic [23:0] widen_rgb565(input logic [15:0] v);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r5 = v[15:11];
        g6 = v[10:5];
        b5 = v[4:0];
        r8 = {r5, r5[4:2]};
        g8 = {g6, g6[5:4]};
        b8 = {b5, b5[4:2]};
        if (r8 < 8'd32 && g8 < 8'd32 && b8 < 8'd32) begin
            return WHITE;
        end
        return {r8, g8, b8};
    endfunction

    task automatic add_glyph(input logic [7:0] ch, input logic seg);
        run_buf[run_len] = '{ch, ink[23:16], ink[15:8], ink[7:0], seg, 1'b0};
        run_len++;
    endtask

    // failed token: form-feed alone, then the held digits as a fresh segment
    task automatic abandon_token();
        int i;
        add_glyph(FORM_FEED, 1'b1);
        for (i = 0; i < tok_digits; i++) begin
            add_glyph(CHAR_ZERO + tok_buf[i], i == 0);
        end
        new_segment = (tok_digits == 3'd0);
        tok_open = 1'b0;
        tok_digits = 3'd0;
        tok_value = 17'd0;
    endtask

    // step the model by one accepted text word and queue the glyphs it yields
    task automatic parse_byte(input logic [7:0] ch, input logic last);
        logic is_digit;
        logic taken;
        int   i;
        is_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
        taken = 1'b0;
        run_len = 0;
        if (tok_open) begin
            if (is_digit) begin
                tok_value = tok_value * 17'd10 + (ch - CHAR_ZERO);
                if (tok_digits >= TOKEN_DIGITS - 1) begin
                    // last digit: the token takes effect, nothing shown
                    ink = widen_rgb565(tok_value[15:0]);
                    new_segment = 1'b1;
                    tok_open = 1'b0;
                    tok_digits = 3'd0;
                    tok_value = 17'd0;
                end else begin
                    tok_buf[tok_digits[1:0]] = ch[3:0];
                    tok_digits = tok_digits + 3'd1;
                end
                taken = 1'b1;
            end else begin
                abandon_token();
            end
        end
        if (!taken) begin
            if (ch == FORM_FEED) begin
                tok_open = 1'b1;
                tok_digits = 3'd0;
                tok_value = 17'd0;
                new_segment = 1'b1;
            end else begin
                add_glyph(ch, new_segment);
                new_segment = 1'b0;
            end
        end
        if (last) begin
            // end of text flushes any open token and goes back to white
            if (tok_open) begin
                abandon_token();
            end
            ink = WHITE;
            new_segment = 1'b1;
        end
        for (i = 0; i < run_len; i++) begin
            if (i == run_len - 1) begin
                run_buf[i].last = 1'b1;
            end
            expected_glyphs.push_back(run_buf[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // every hundredth word or so waits for the output side to drain first
    task automatic push_byte(input logic [7:0] ch, input logic last);
        text_queue.push_back('{ch, last, (items_queued % 100) == 50});
        items_queued++;
    endtask

    // form-feed plus the leading ndigits of value written as five decimal digits
    task automatic push_token(input int value, input int ndigits, input logic end_last);
        int i;
        int place;
        int d;
        push_byte(FORM_FEED, end_last && ndigits == 0);
        place = 10000;
        for (i = 0; i < ndigits; i++) begin
            d = (value / place) % 10;
            push_byte(CHAR_ZERO + d[7:0], end_last && i == ndigits - 1);
            place = place / 10;
        end
    endtask

    function automatic logic [7:0] random_byte();
        logic [31:0] r;
        r = $urandom_range(1, 255);
        return r[7:0];
    endfunction

    function automatic logic [7:0] random_nondigit();
        logic [7:0] c;
        c = CHAR_ZERO;
        while (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            c = random_byte();
        end
        return c;
    endfunction

    task automatic report(input string what, input glyph_t want, input glyph_t seen);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t %0s: expected char %h rgb %h%h%h seg %b last %b", $time, what,
                     want.ch, want.red, want.green, want.blue, want.seg, want.last);
            $display("    got char %h rgb %h%h%h seg %b last %b",
                     seen.ch, seen.red, seen.green, seen.blue, seen.seg, seen.last);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of text words with random gaps, model stepped on accept
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        text_item_t nxt;
        logic       show;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_text_byte, s_text_end);
                items_accepted++;
            end
            // only move on once the word on the bus has gone
            if (!s_valid || s_ready) begin
                show = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (text_queue.size() != 0 &&
                             !(text_queue[0].drain_first && expected_glyphs.size() != 0)) begin
                    nxt = text_queue.pop_front();
                    show = 1'b1;
                    s_text_byte <= nxt.ch;
                    s_text_end <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                s_valid <= show;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check each glyph word in order, shape m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        glyph_t seen;
        glyph_t want;
        int     pick;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_out_char, m_red, m_green, m_blue, m_segment_start, m_run_last};
            if (expected_glyphs.size() == 0) begin
                report("unexpected glyph", '0, seen);
            end else begin
                want = expected_glyphs.pop_front();
                if (seen !== want) begin
                    report("glyph mismatch", want, seen);
                end
            end
        end

        // stall pattern: free running, coin toss, or long chokes, each for a while
        if (sink_phase == 0) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                sink_mode = SINK_OPEN;
            end else if (pick == 1) begin
                sink_mode = SINK_COIN;
            end else begin
                sink_mode = SINK_CHOKE;
            end
            sink_phase = $urandom_range(20, 120);
        end else begin
            sink_phase--;
        end
        case (sink_mode)
            SINK_OPEN: begin
                m_ready <= 1'b1;
            end
            SINK_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (choke_left != 0) begin
                    choke_left--;
                    m_ready <= 1'b0;
                end else begin
                    choke_left = $urandom_range(1, 12);
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int pick;
        int run;
        int i;
        int n;

        // directed words
        push_byte(8'hFF, 1'b0);                     // top byte, first word opens a segment
        push_token(99999, TOKEN_DIGITS, 1'b0);      // value wraps past 16 bits
        push_token(12000, 2, 1'b1);                 // text ends inside a token with digits
        push_token(1, TOKEN_DIGITS, 1'b0);          // near black turns white
        push_token(0, 0, 1'b0);                     // form-feed then form-feed: empty failure
        push_token(0, 0, 1'b0);
        push_byte("q", 1'b0);                       // empty failure, byte starts a segment
        push_token(12340, TOKEN_DIGITS - 1, 1'b0);  // four digits then a letter: six words
        push_byte("k", 1'b1);
        push_token(0, 0, 1'b1);                     // form-feed as the last byte of a text

        // random part: good tokens with text after most often, some broken, some noise
        while (items_queued < TEXT_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                push_token($urandom_range(0, 99999), TOKEN_DIGITS, $urandom_range(0, 9) == 0);
                run = $urandom_range(1, 6);
                for (i = 0; i < run; i++) begin
                    push_byte(random_byte(), $urandom_range(0, 19) == 0);
                end
            end else if (pick < 65) begin
                n = $urandom_range(0, TOKEN_DIGITS - 1);
                if ($urandom_range(0, 1) == 1) begin
                    push_token($urandom_range(0, 99999), n, 1'b1);
                end else begin
                    push_token($urandom_range(0, 99999), n, 1'b0);
                    push_byte(random_nondigit(), $urandom_range(0, 7) == 0);
                end
            end else begin
                push_byte(random_byte(), $urandom_range(0, 19) == 0);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // all text words taken, then all glyphs back, then a short settle
        while (items_accepted != items_queued) begin
            @(posedge aclk);
        end
        while (expected_glyphs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (expected_glyphs.size() != 0) begin
            $display("%0d glyph words never arrived", expected_glyphs.size());
            error_count += expected_glyphs.size();
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
